// ----- rtl/core/skt_pkg.sv -----
// Shared types and codes of the sorted key table.
package skt_pkg;

	localparam int KEY_BITS  = 64;
	localparam int KEY_BYTES = 8;

	// Operation codes carried by a request.
	localparam logic [1:0] OP_SEARCH = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_LIST   = 2'd3;

	// Result status codes.
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_FULL      = 3'd1;
	localparam logic [2:0] STAT_EMPTY     = 3'd2;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
	localparam logic [2:0] STAT_BAD_KEY   = 3'd4;

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic [1:0]          op;
		logic [KEY_BITS-1:0] key;
		logic                key_ok;
	} skt_item_t;

	// One result as driven to the output ports.
	typedef struct packed {
		logic                strobe;
		logic [2:0]          status;
		logic [3:0]          position;
		logic [KEY_BITS-1:0] entry_key;
		logic [4:0]          match_count;
		logic                last;
	} skt_result_t;

	// Sequencer states of the back end.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_FINISH
	} back_state_t;

endpackage

// ----- rtl/core/skt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/skt_front.sv -----
// Front end: accepts requests, validates and canonicalizes the key.
module skt_front #(
	parameter int MAX_CHARS = 8
) (
	input  logic                start,
	input  logic [1:0]          opcode,
	input  logic [63:0]         key_chars,
	input  logic [3:0]          key_length,
	input  logic                queue_full,
	output logic                busy,
	output logic                push,
	output skt_pkg::skt_item_t  item
);
	import skt_pkg::*;

	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_LOWER_Z = 8'd122;

	logic [KEY_BITS-1:0] key_canon;
	logic                char_bad;
	logic                len_bad;

	// Check each character inside the length and clear the padding bytes.
	always_comb begin
		logic [7:0] ch;
		logic       in_key;
		logic       letter;
		key_canon = '0;
		char_bad  = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			ch     = key_chars[KEY_BITS-1-8*i -: 8];
			in_key = 4'(i) < key_length;
			letter = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
				(ch >= CH_LOWER_A && ch <= CH_LOWER_Z);
			if (in_key) begin
				key_canon[KEY_BITS-1-8*i -: 8] = ch;
				if (!letter) begin
					char_bad = 1'b1;
				end
			end
		end
	end

	assign len_bad = (key_length == 4'd0) || (key_length > 4'(MAX_CHARS));

	// A request is taken whenever the queue has room.
	assign busy        = queue_full;
	assign push        = start && !queue_full;
	assign item.op     = opcode;
	assign item.key    = key_canon;
	assign item.key_ok = !len_bad && !char_bad;

endmodule

// ----- rtl/core/skt_queue.sv -----
// Two-entry queue between the front end and the back end.
module skt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  skt_pkg::skt_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output skt_pkg::skt_item_t head_item
);
	import skt_pkg::*;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	skt_item_t        mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;

	assign full       = cnt_q == QCW'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head_item  = mem_q[rd_ptr_q];

	// Storage is payload only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QAW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QAW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= QCW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= QCW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

// ----- rtl/core/skt_back.sv -----
// Back end: walks the stored table to search, insert, delete and list.
module skt_back #(
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  skt_pkg::skt_item_t   item,
	output logic                 item_pop,
	output skt_pkg::skt_result_t result
);
	import skt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	back_state_t         state_q, state_d;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rem_q;
	logic [AW-1:0]       rd_idx_q;
	logic [CW-1:0]       n_q;
	logic [AW-1:0]       pos_q;
	logic                hit_q;
	logic                dv_s1;
	logic [AW-1:0]       didx_s1;
	skt_result_t         result_q, res_d;

	logic                ren;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [KEY_BITS-1:0] wdata;
	logic [KEY_BITS-1:0] rdata;

	logic [CW-1:0]       cnt_m1;
	logic [CW-1:0]       cnt_p1;
	logic                is_eq;
	logic                is_gt;
	logic                place_now;
	logic                scan_end;
	logic                err_valid;
	logic [2:0]          err_code;

	skt_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ren),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	assign cnt_m1    = CW'(count_q - 1'b1);
	assign cnt_p1    = CW'(count_q + 1'b1);
	assign is_eq     = rdata == key_q;
	assign is_gt     = rdata > key_q;
	assign place_now = (state_q == BK_RUN) && dv_s1 && (op_q == OP_INSERT) &&
		!hit_q && !is_gt;
	assign scan_end  = ((rem_q == '0) && !dv_s1) || place_now;
	assign ren       = (state_q == BK_RUN) && (rem_q != '0);

	// Classify the queued request against the table fill and its key check.
	always_comb begin
		err_valid = 1'b0;
		err_code  = STAT_OK;
		unique case (item.op)
			OP_LIST: begin
				if (count_q == '0) begin
					err_valid = 1'b1;
					err_code  = STAT_EMPTY;
				end
			end
			OP_INSERT: begin
				if (count_q == CW'(DEPTH)) begin
					err_valid = 1'b1;
					err_code  = STAT_FULL;
				end else if (!item.key_ok) begin
					err_valid = 1'b1;
					err_code  = STAT_BAD_KEY;
				end
			end
			default: begin
				if (count_q == '0) begin
					err_valid = 1'b1;
					err_code  = STAT_EMPTY;
				end else if (!item.key_ok) begin
					err_valid = 1'b1;
					err_code  = STAT_BAD_KEY;
				end
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (item_valid && !err_valid) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (scan_end) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH: begin
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Outputs: queue pop, table writes and the next result.
	always_comb begin
		item_pop = 1'b0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = key_q;
		res_d    = '0;
		unique case (state_q)
			BK_IDLE: begin
				item_pop = item_valid;
				if (item_valid && err_valid) begin
					res_d.strobe = 1'b1;
					res_d.status = err_code;
					res_d.last   = 1'b1;
				end
			end
			BK_RUN: begin
				if (dv_s1) begin
					unique case (op_q)
						OP_LIST: begin
							res_d.strobe    = 1'b1;
							res_d.status    = STAT_OK;
							res_d.position  = 4'(didx_s1);
							res_d.entry_key = rdata;
							res_d.last      = didx_s1 == cnt_m1[AW-1:0];
						end
						OP_SEARCH: begin
							// A new match releases the one held back.
							if (is_eq && (n_q != '0)) begin
								res_d.strobe      = 1'b1;
								res_d.status      = STAT_OK;
								res_d.position    = 4'(pos_q);
								res_d.entry_key   = key_q;
								res_d.match_count = 5'(n_q);
							end
						end
						OP_INSERT: begin
							// Walking down: move greater keys up until the slot is found.
							if (!hit_q) begin
								we    = 1'b1;
								waddr = AW'(didx_s1 + 1'b1);
								wdata = is_gt ? rdata : key_q;
							end
						end
						default: begin
							// Delete: after the match, each entry moves down one slot.
							if (hit_q) begin
								we    = 1'b1;
								waddr = AW'(didx_s1 - 1'b1);
								wdata = rdata;
							end
						end
					endcase
				end
			end
			BK_FINISH: begin
				unique case (op_q)
					OP_SEARCH: begin
						res_d.strobe = 1'b1;
						res_d.last   = 1'b1;
						if (n_q != '0) begin
							res_d.status      = STAT_OK;
							res_d.position    = 4'(pos_q);
							res_d.entry_key   = key_q;
							res_d.match_count = 5'(n_q);
						end else begin
							res_d.status = STAT_NOT_FOUND;
						end
					end
					OP_INSERT: begin
						res_d.strobe      = 1'b1;
						res_d.status      = STAT_OK;
						res_d.position    = hit_q ? 4'(pos_q) : 4'd0;
						res_d.match_count = 5'(cnt_p1);
						res_d.last        = 1'b1;
						// Every stored key was greater: the new key goes first.
						if (!hit_q) begin
							we    = 1'b1;
							waddr = '0;
						end
					end
					OP_DELETE: begin
						res_d.strobe = 1'b1;
						res_d.last   = 1'b1;
						if (hit_q) begin
							res_d.status      = STAT_OK;
							res_d.position    = 4'(pos_q);
							res_d.match_count = 5'(cnt_m1);
						end else begin
							res_d.status = STAT_NOT_FOUND;
						end
					end
					default: begin
						res_d = '0;
					end
				endcase
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// Walk registers and request payload.
	always_ff @(posedge clk) begin
		didx_s1 <= rd_idx_q;
		if (state_q == BK_IDLE && item_valid) begin
			op_q     <= item.op;
			key_q    <= item.key;
			rem_q    <= count_q;
			rd_idx_q <= (item.op == OP_INSERT) ? cnt_m1[AW-1:0] : '0;
			n_q      <= '0;
			hit_q    <= 1'b0;
		end else if (state_q == BK_RUN) begin
			if (ren) begin
				rd_idx_q <= (op_q == OP_INSERT) ? AW'(rd_idx_q - 1'b1) :
					AW'(rd_idx_q + 1'b1);
				rem_q    <= CW'(rem_q - 1'b1);
			end
			if (dv_s1) begin
				if (op_q == OP_SEARCH && is_eq) begin
					n_q   <= CW'(n_q + 1'b1);
					pos_q <= didx_s1;
				end else if (place_now) begin
					hit_q <= 1'b1;
					pos_q <= AW'(didx_s1 + 1'b1);
				end else if (op_q == OP_DELETE && !hit_q && is_eq) begin
					hit_q <= 1'b1;
					pos_q <= didx_s1;
				end
			end
		end
	end

	// Control state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			count_q  <= '0;
			dv_s1    <= 1'b0;
			result_q <= '0;
		end else begin
			state_q  <= state_d;
			dv_s1    <= ren;
			result_q <= res_d;
			if (state_q == BK_FINISH) begin
				if (op_q == OP_INSERT) begin
					count_q <= cnt_p1;
				end else if (op_q == OP_DELETE && hit_q) begin
					count_q <= cnt_m1;
				end
			end
		end
	end

	assign result = result_q;

endmodule

// ----- rtl/core/sorted_key_table_core.sv -----
// Top level of the sorted key table: front end, request queue and back end.
// Keeps up to DEPTH keys of up to MAX_CHARS letters in ascending order. A request
// is taken when start is high and busy is low; busy rises only while the two-entry
// request queue is full. A request rejected for a full or empty table or a bad key
// yields one registered result as it leaves the queue. Otherwise the back end walks
// the stored entries through the table RAM, one read per cycle. The request first
// leaves the queue, each entry held is read, the last read data returns, the walk
// closes and the finish state ends the request. Insert stops early
// once its slot is found. List streams one result per cycle as entries come out of
// the RAM; search holds each match back until the next one or the end of the walk,
// and insert and delete shift entries during the same walk. Every result appears
// for one cycle under strobe and must be taken then; the receiver cannot stall it.
// The table RAM needs no clearing after reset.
module sorted_key_table_core #(
	parameter int DEPTH     = 16,
	parameter int MAX_CHARS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [63:0] key_chars,
	input  logic [3:0]  key_length,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [3:0]  position,
	output logic [63:0] entry_key,
	output logic [4:0]  match_count,
	output logic        last
);
	import skt_pkg::*;

	logic        push;
	logic        queue_full;
	logic        head_valid;
	logic        head_pop;
	skt_item_t   push_item;
	skt_item_t   head_item;
	skt_result_t result;

	skt_front #(
		.MAX_CHARS(MAX_CHARS)
	) u_front (
		.start     (start),
		.opcode    (opcode),
		.key_chars (key_chars),
		.key_length(key_length),
		.queue_full(queue_full),
		.busy      (busy),
		.push      (push),
		.item      (push_item)
	);

	skt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (head_pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	skt_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(head_valid),
		.item      (head_item),
		.item_pop  (head_pop),
		.result    (result)
	);

	// Result ports.
	assign strobe      = result.strobe;
	assign status      = result.status;
	assign position    = result.position;
	assign entry_key   = result.entry_key;
	assign match_count = result.match_count;
	assign last        = result.last;

endmodule
